// ----- rtl/rbf_pkg.sv -----
package rbf_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PIX_W     = NUM_LANES * BYTE_W;
  localparam int unsigned PROD_W    = 2 * BYTE_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  // floor(p / 255) for 16-bit p: (p * RECIP_255) >> RECIP_SHIFT
  localparam logic [PROD_W-1:0] RECIP_255   = 16'h8081;
  localparam int unsigned       RECIP_SHIFT = 23;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA = 1'b1;

  typedef enum logic [3:0] {
    MODE_ZERO      = 4'd0,
    MODE_ONE       = 4'd1,
    MODE_DST_COLOR = 4'd2,
    MODE_SRC_COLOR = 4'd3,
    MODE_INV_DST   = 4'd4,
    MODE_INV_SRC   = 4'd5,
    MODE_SRC_ALPHA = 4'd6,
    MODE_INV_SRC_A = 4'd7,
    MODE_DST_ALPHA = 4'd8,
    MODE_INV_DST_A = 4'd9,
    MODE_SATURATE  = 4'd10
  } blend_mode_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic s1_full;
  } pipe_en_t;

endpackage

// ----- rtl/rbf_ctrl.sv -----
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output pipe_en_t pipe_en
);

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic ld1, ld2;

  assign ld2      = v1_r & (~v2_r | ~out_stall);
  assign in_stall = v1_r & ~ld2;
  assign ld1      = in_valid & ~in_stall;

  assign v1_nxt = ld1 | (v1_r & ~ld2);
  assign v2_nxt = ld2 | (v2_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign out_valid       = v2_r;
  assign pipe_en.ld1     = ld1;
  assign pipe_en.ld2     = ld2;
  assign pipe_en.s1_full = v1_r;

endmodule

// ----- rtl/rbf_lane.sv -----
module rbf_lane
  import rbf_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          pipe_en,
  input  logic [3:0]        mode,
  input  logic              is_alpha,
  input  logic [BYTE_W-1:0] wt_byte,
  input  logic [BYTE_W-1:0] src_byte,
  input  logic [BYTE_W-1:0] dst_byte,
  input  logic [BYTE_W-1:0] src_alpha,
  input  logic [BYTE_W-1:0] dst_alpha,
  output logic [BYTE_W-1:0] result
);

  logic [BYTE_W-1:0]   factor;
  logic [BYTE_W-1:0]   sat_f;
  logic                force_max;
  logic [PROD_W-1:0]   prod_r;
  logic                force_r;
  logic [2*PROD_W-1:0] recip_prod;
  logic [BYTE_W-1:0]   quot;
  logic [BYTE_W-1:0]   res_r;

  assign sat_f = (src_alpha < ~dst_alpha) ? src_alpha : ~dst_alpha;

  always_comb begin
    unique case (blend_mode_t'(mode))
      MODE_ONE:       factor = BYTE_MAX;
      MODE_DST_COLOR: factor = dst_byte;
      MODE_SRC_COLOR: factor = src_byte;
      MODE_INV_DST:   factor = ~dst_byte;
      MODE_INV_SRC:   factor = ~src_byte;
      MODE_SRC_ALPHA: factor = src_alpha;
      MODE_INV_SRC_A: factor = ~src_alpha;
      MODE_DST_ALPHA: factor = dst_alpha;
      MODE_INV_DST_A: factor = ~dst_alpha;
      MODE_SATURATE:  factor = sat_f;
      default:        factor = '0;
    endcase
  end

  assign force_max = (blend_mode_t'(mode) == MODE_SATURATE) && is_alpha;

  always_ff @(posedge clk) begin
    if (pipe_en.ld1) begin
      prod_r  <= wt_byte * factor;
      force_r <= force_max;
    end
  end

  // exact divide by 255
  assign recip_prod = prod_r * RECIP_255;
  assign quot       = recip_prod[RECIP_SHIFT +: BYTE_W];

  always_ff @(posedge clk) begin
    if (pipe_en.ld2) begin
      res_r <= force_r ? BYTE_MAX : quot;
    end
  end

  assign result = res_r;

endmodule

// ----- rtl/rgba_blend_factor_unit.sv -----
// Channel   Ports                                        Direction
// request   in_valid/in_stall, weighted/source/dest_pixel in
// result    out_valid/out_stall, out_channel_0..3         out
// config    cfg_we, cfg_index, cfg_wdata                  in
//
// Two-stage pipeline, one request per cycle unless out_stall holds a result;
// a request is registered in stage 1, then in stage 2, where out_valid rises.
// Stage 1 selects the factor and multiplies per lane, stage 2 divides by 255
// with a reciprocal multiply and holds the result.
// Reset (synchronous, rst_n low) empties the pipeline, mode = one, RGBA.
// A stalled result holds; stage 1 takes one more request, then in_stall rises.
module rgba_blend_factor_unit
  import rbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_weighted_pixel,
  input  logic [PIX_W-1:0]     in_source_pixel,
  input  logic [PIX_W-1:0]     in_dest_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_channel_0,
  output logic [BYTE_W-1:0]    out_channel_1,
  output logic [BYTE_W-1:0]    out_channel_2,
  output logic [BYTE_W-1:0]    out_channel_3
);

  logic [3:0]        mode_r;
  logic              alpha_first_r;
  pipe_en_t          pipe_en;
  logic [BYTE_W-1:0] src_alpha;
  logic [BYTE_W-1:0] dst_alpha;
  logic [BYTE_W-1:0] lane_res [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ONE;
      alpha_first_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE:  mode_r        <= cfg_wdata;
        CFG_IDX_ALPHA: alpha_first_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign src_alpha = alpha_first_r ? in_source_pixel[BYTE_W-1:0]
                                   : in_source_pixel[PIX_W-1 -: BYTE_W];
  assign dst_alpha = alpha_first_r ? in_dest_pixel[BYTE_W-1:0]
                                   : in_dest_pixel[PIX_W-1 -: BYTE_W];

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pipe_en  (pipe_en)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam bit ALPHA_LO = (i == 0);
    localparam bit ALPHA_HI = (i == NUM_LANES - 1);

    rbf_lane u_lane (
      .clk      (clk),
      .pipe_en  (pipe_en),
      .mode     (mode_r),
      .is_alpha (alpha_first_r ? ALPHA_LO : ALPHA_HI),
      .wt_byte  (in_weighted_pixel[i*BYTE_W +: BYTE_W]),
      .src_byte (in_source_pixel[i*BYTE_W +: BYTE_W]),
      .dst_byte (in_dest_pixel[i*BYTE_W +: BYTE_W]),
      .src_alpha(src_alpha),
      .dst_alpha(dst_alpha),
      .result   (lane_res[i])
    );
  end

  assign out_channel_0 = lane_res[0];
  assign out_channel_1 = lane_res[1];
  assign out_channel_2 = lane_res[2];
  assign out_channel_3 = lane_res[3];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> pipe_en.s1_full && out_valid && out_stall)
    else $error("request stalled without a blocked result");

  a_stage2_load: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en.ld2 |=> out_valid)
    else $error("stage 2 load lost");

  a_stage1_load: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en.ld1 |=> pipe_en.s1_full)
    else $error("stage 1 load lost");
`endif

endmodule

// ----- bench/rgba_blend_factor_unit_test.sv -----
module rgba_blend_factor_unit_test;
  import rbf_pkg::*;

  localparam logic [CFG_DAT_W-1:0] MODE_CODE_TOP = 4'hF;

  typedef struct {
    logic [PIX_W-1:0] weighted;
    logic [PIX_W-1:0] source;
    logic [PIX_W-1:0] dest;
  } pixel_req_t;

  typedef logic [NUM_LANES-1:0][BYTE_W-1:0] chan_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] in_weighted_pixel = '0;
  logic [PIX_W-1:0] in_source_pixel = '0;
  logic [PIX_W-1:0] in_dest_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] out_channel_0;
  logic [BYTE_W-1:0] out_channel_1;
  logic [BYTE_W-1:0] out_channel_2;
  logic [BYTE_W-1:0] out_channel_3;

  // shadow copy of the block's registers
  logic [CFG_DAT_W-1:0] mode_q;
  logic alpha_first_q;

  pixel_req_t pend_q[$];
  chan_set_t blend_exp_q[$];
  int unsigned n_queued = 0;
  int unsigned n_done = 0;
  int unsigned err_cnt = 0;
  int unsigned cfg_writes = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  rgba_blend_factor_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_weighted_pixel(in_weighted_pixel),
    .in_source_pixel  (in_source_pixel),
    .in_dest_pixel    (in_dest_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel_0    (out_channel_0),
    .out_channel_1    (out_channel_1),
    .out_channel_2    (out_channel_2),
    .out_channel_3    (out_channel_3)
  );

  always #1 clk = ~clk;

  function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] x,
                                                   input logic [BYTE_W-1:0] f);
    logic [PROD_W-1:0] p;
    p = x * f;
    return BYTE_W'(p / 255);
  endfunction

  function automatic chan_set_t predict_blend(input logic [PIX_W-1:0] w,
                                              input logic [PIX_W-1:0] s,
                                              input logic [PIX_W-1:0] d,
                                              input logic [CFG_DAT_W-1:0] mode,
                                              input logic af);
    chan_set_t r;
    int unsigned apos;
    logic [BYTE_W-1:0] sa, da, x, f;
    apos = af ? 0 : 3;
    sa = s[8*apos +: 8];
    da = d[8*apos +: 8];
    for (int i = 0; i < NUM_LANES; i++) begin
      x = w[8*i +: 8];
      case (mode)
        MODE_ONE:       r[i] = x;
        MODE_DST_COLOR: r[i] = scale_byte(x, d[8*i +: 8]);
        MODE_SRC_COLOR: r[i] = scale_byte(x, s[8*i +: 8]);
        MODE_INV_DST:   r[i] = scale_byte(x, BYTE_MAX - d[8*i +: 8]);
        MODE_INV_SRC:   r[i] = scale_byte(x, BYTE_MAX - s[8*i +: 8]);
        MODE_SRC_ALPHA: r[i] = scale_byte(x, sa);
        MODE_INV_SRC_A: r[i] = scale_byte(x, BYTE_MAX - sa);
        MODE_DST_ALPHA: r[i] = scale_byte(x, da);
        MODE_INV_DST_A: r[i] = scale_byte(x, BYTE_MAX - da);
        MODE_SATURATE: begin
          f = (sa < BYTE_MAX - da) ? sa : BYTE_MAX - da;
          r[i] = (i == apos) ? BYTE_MAX : scale_byte(x, f);
        end
        default:        r[i] = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    for (int i = 0; i < NUM_LANES; i++) begin
      case ($urandom_range(7))
        0:       p[8*i +: 8] = 8'h00;
        1:       p[8*i +: 8] = 8'hFF;
        2:       p[8*i +: 8] = 8'h01;
        3:       p[8*i +: 8] = 8'hFE;
        default: p[8*i +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // request driver and shadow registers
  always @(posedge clk) begin
    pixel_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      mode_q <= MODE_ONE;
      alpha_first_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_MODE) begin
          mode_q <= cfg_wdata;
        end else begin
          alpha_first_q <= cfg_wdata[0];
        end
      end
      if (in_valid && !in_stall) begin
        blend_exp_q.push_back(predict_blend(in_weighted_pixel, in_source_pixel,
                                            in_dest_pixel, mode_q, alpha_first_q));
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pend_q.pop_front();
          in_valid <= 1'b1;
          in_weighted_pixel <= req.weighted;
          in_source_pixel <= req.source;
          in_dest_pixel <= req.dest;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    chan_set_t exp_chan, got_chan;
    if (rst_n && out_valid && !out_stall) begin
      got_chan = {out_channel_3, out_channel_2, out_channel_1, out_channel_0};
      if (blend_exp_q.size() == 0) begin
        $error("result with no request pending: %h", got_chan);
        err_cnt++;
      end else begin
        exp_chan = blend_exp_q.pop_front();
        for (int i = 0; i < NUM_LANES; i++) begin
          if (got_chan[i] !== exp_chan[i]) begin
            $error("out_channel_%0d: expected %h, got %h", i, exp_chan[i], got_chan[i]);
            err_cnt++;
          end
        end
        n_done++;
      end
    end
  end

  task automatic queue_req(input logic [PIX_W-1:0] w, input logic [PIX_W-1:0] s,
                           input logic [PIX_W-1:0] d);
    pixel_req_t req;
    req.weighted = w;
    req.source = s;
    req.dest = d;
    pend_q.push_back(req);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_done != n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic queue_random(input int unsigned n);
    for (int k = 0; k < n; k++) begin
      queue_req(rand_pixel(), rand_pixel(), rand_pixel());
    end
  endtask

  initial begin
    logic [CFG_DAT_W-1:0] mode;
    logic af;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: mode one, RGBA
    queue_req('0, '0, '0);
    queue_req('1, '1, '1);
    queue_req(32'hA55A_0FF0, '0, '1);
    wait_drained();

    write_reg(CFG_IDX_MODE, MODE_ZERO);
    queue_req('1, '1, '1);
    queue_req(32'h8001_FE7F, 32'h1234_5678, 32'h9ABC_DEF0);
    wait_drained();

    // alpha saturate: sa below, above and equal to 255-da, and da full
    write_reg(CFG_IDX_MODE, MODE_SATURATE);
    queue_req('1, 32'h80FF_FFFF, 32'h40FF_FFFF);
    queue_req('1, 32'hF000_0000, 32'h4000_0000);
    queue_req(32'h1280_FF01, 32'hBF11_2233, 32'h4044_5566);
    queue_req('1, '1, '1);
    wait_drained();
    write_reg(CFG_IDX_ALPHA, 4'h1);
    queue_req('1, 32'hFFFF_FF80, 32'hFFFF_FF40);
    queue_req('1, 32'h0000_00F0, 32'h0000_0040);
    queue_req(32'h01FF_8012, 32'h3322_11BF, 32'h6655_4440);
    queue_req('1, '1, '1);
    wait_drained();

    // undefined mode codes behave as zero
    write_reg(CFG_IDX_MODE, MODE_CODE_TOP);
    queue_req('1, '1, '1);
    queue_req(32'h5A5A_A5A5, 32'hFF00_FF00, 32'h00FF_00FF);
    wait_drained();

    for (int p = 0; p < 32; p++) begin
      mode = CFG_DAT_W'(p % 16);
      af = (p >= 16);
      case ((p + p / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      write_reg(CFG_IDX_ALPHA, {3'($urandom_range(7)), af});
      write_reg(CFG_IDX_MODE, mode);
      queue_random(10);
      // sender holds off until the pipeline is empty
      while (n_done != n_queued) @(posedge clk);
      queue_random(10);
      wait_drained();
    end

    $display("covered %0d requests over all 16 mode codes, both alpha positions,",
             n_queued);
    $display("%0d register writes and four idle/stall profiles", cfg_writes);
    if (err_cnt == 0 && blend_exp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout: %0d of %0d requests done", n_done, n_queued);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
